### rtl/zrse_pkg.sv
// Shared constants, state encoding and control structs for the zero-run symbol encoder.
package zrse_pkg;

  localparam int COUNT_BITS = 32;
  localparam int RUN_W      = COUNT_BITS + 1;  // run value holds zero count plus one
  localparam int RANK_W     = 8;
  localparam int SYM_W      = 9;

  localparam logic [SYM_W-1:0] SYM_RUNA = SYM_W'(0);
  localparam logic [SYM_W-1:0] SYM_RUNB = SYM_W'(1);
  localparam logic [SYM_W-1:0] SYM_EOB  = SYM_W'(257);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_RANK,
    ST_EOB
  } zrse_state_t;

  // Commands from the sequencer to the run unit.
  typedef struct packed {
    logic inc;    // add one zero to the pending run
    logic shift;  // drop the digit just emitted
  } zrse_cmd_t;

  // Status of the run unit.
  typedef struct packed {
    logic digit;       // low bit of the run value: 1 gives RUNB, 0 gives RUNA
    logic pending;     // at least one digit left to emit
    logic last_digit;  // exactly one digit left to emit
  } zrse_stat_t;

  // Symbol offered to the output register.
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             run_last;
  } zrse_emit_t;

endpackage

### rtl/zrse_if.sv
// Valid/ready channel interfaces for rank input and symbol output.
interface zrse_in_if;
  import zrse_pkg::*;

  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] mtf_rank;
  logic              block_last;

  modport source (output valid, output mtf_rank, output block_last, input ready);
  modport sink   (input valid, input mtf_rank, input block_last, output ready);
endinterface

interface zrse_out_if;
  import zrse_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             run_last;

  modport source (output valid, output symbol, output run_last, input ready);
  modport sink   (input valid, input symbol, input run_last, output ready);
endinterface

### rtl/zrse_run_unit.sv
// Run register with its shared incrementer and digit shifter.
module zrse_run_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  zrse_pkg::zrse_cmd_t  cmd,
  output zrse_pkg::zrse_stat_t stat
);
  import zrse_pkg::*;

  // run_r = zero count + 1; it reads 1 when no zeros are pending, and
  // shifting out the bijective digits brings it back to 1 by itself.
  logic [RUN_W-1:0] run_r;
  logic [RUN_W-1:0] run_nxt;
  logic [RUN_W-1:0] run_shr;

  assign run_shr = run_r >> 1;

  always_comb begin
    run_nxt = run_r;
    if (cmd.inc) begin
      // saturate once the top bit is set (count at its maximum)
      run_nxt = run_r + {{(RUN_W-1){1'b0}}, ~run_r[RUN_W-1]};
    end else if (cmd.shift) begin
      run_nxt = run_shr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= RUN_W'(1);
    end else begin
      run_r <= run_nxt;
    end
  end

  assign stat.digit      = run_r[0];
  assign stat.pending    = |run_shr;
  assign stat.last_digit = (run_shr == RUN_W'(1));

endmodule

### rtl/zrse_ctrl.sv
// Sequencer: accepts ranks and steps through run digits, rank symbol and end of block.
module zrse_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [zrse_pkg::RANK_W-1:0] in_rank,
  input  logic                       in_last,
  output logic                       in_ready,
  input  logic                       out_free,
  input  zrse_pkg::zrse_stat_t       stat,
  output zrse_pkg::zrse_cmd_t        cmd,
  output zrse_pkg::zrse_emit_t       emit
);
  import zrse_pkg::*;

  zrse_state_t       state_r, state_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    last_r <= last_nxt;
  end

  // ready is high only in ST_IDLE and emit is valid in every other state,
  // so the handshakes reduce to in_valid and out_free there
  always_comb begin
    state_nxt     = state_r;
    rank_nxt      = rank_r;
    last_nxt      = last_r;
    in_ready      = 1'b0;
    cmd           = '0;
    emit.valid    = 1'b0;
    emit.symbol   = SYM_RUNA;
    emit.run_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rank_nxt = in_rank;
          last_nxt = in_last;
          if (in_rank != '0) begin
            state_nxt = stat.pending ? ST_RUN : ST_RANK;
          end else begin
            cmd.inc = 1'b1;
            // a zero on the last byte always leaves a nonempty run
            if (in_last) begin
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        emit.valid  = 1'b1;
        emit.symbol = stat.digit ? SYM_RUNB : SYM_RUNA;
        if (out_free) begin
          cmd.shift = 1'b1;
          if (stat.last_digit) begin
            state_nxt = (rank_r != '0) ? ST_RANK : ST_EOB;
          end
        end
      end
      ST_RANK: begin
        emit.valid    = 1'b1;
        emit.symbol   = {1'b0, rank_r} + SYM_W'(1);
        emit.run_last = ~last_r;
        if (out_free) begin
          state_nxt = last_r ? ST_EOB : ST_IDLE;
        end
      end
      ST_EOB: begin
        emit.valid    = 1'b1;
        emit.symbol   = SYM_EOB;
        emit.run_last = 1'b1;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/zero_run_symbol_encoder_core.sv
// Zero-run symbol encoder top level: sequencer, run unit and output register.
// Zero ranks that do not end a block are absorbed at one per cycle.
// Any other rank stalls the input until its last symbol is offered to the output:
// floor(log2(zeros + 1)) run digits, the rank symbol for a nonzero rank, and the
// end-of-block symbol on the last byte, with the single run register shifting one
// digit a cycle unless output stalls. Accept loads the state register, then the output.
// rst_n is synchronous, active low: it empties the run and the output register.
module zero_run_symbol_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  zrse_in_if.sink     in_bus,
  zrse_out_if.source  out_bus
);
  import zrse_pkg::*;

  zrse_cmd_t  cmd;
  zrse_stat_t stat;
  zrse_emit_t emit;
  logic       out_free;

  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_symbol_r, out_symbol_nxt;
  logic             out_run_last_r, out_run_last_nxt;

  assign out_free = !out_valid_r || out_bus.ready;

  zrse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_rank  (in_bus.mtf_rank),
    .in_last  (in_bus.block_last),
    .in_ready (in_bus.ready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .emit     (emit)
  );

  zrse_run_unit u_run (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // load a new beat whenever the register is empty or being drained
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_symbol_nxt   = out_symbol_r;
    out_run_last_nxt = out_run_last_r;
    if (out_free) begin
      out_valid_nxt    = emit.valid;
      out_symbol_nxt   = emit.symbol;
      out_run_last_nxt = emit.run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_symbol_r   <= out_symbol_nxt;
    out_run_last_r <= out_run_last_nxt;
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.symbol   = out_symbol_r;
  assign out_bus.run_last = out_run_last_r;

endmodule

### rtl/zrse_checker.sv
// Port-level assertions for the zero-run symbol encoder, bound to the top level.
module zrse_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [zrse_pkg::RANK_W-1:0] in_mtf_rank,
  input logic                        in_block_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [zrse_pkg::SYM_W-1:0]  out_symbol,
  input logic                        out_run_last
);
  import zrse_pkg::*;

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(out_run_last))
    else $error("stalled output beat changed");

  // a nonzero rank always produces symbols, so input must stall
  a_rank_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mtf_rank != '0) |=> !in_ready)
    else $error("input ready after nonzero rank");

  // a zero inside the block is only counted
  a_zero_absorbed: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mtf_rank == '0) && !in_block_last |=> in_ready)
    else $error("zero rank stalled the input");

  a_eob_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_symbol == SYM_EOB) |-> out_run_last)
    else $error("end of block not marked last");

  a_digit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_symbol == SYM_RUNA) || (out_symbol == SYM_RUNB)) |-> !out_run_last)
    else $error("run digit marked last");

endmodule

bind zero_run_symbol_encoder_core zrse_checker u_zrse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .in_mtf_rank   (in_bus.mtf_rank),
  .in_block_last (in_bus.block_last),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_symbol    (out_bus.symbol),
  .out_run_last  (out_bus.run_last)
);
